@@ src/ucw_pkg.sv @@
`default_nettype none
package ucw_pkg;

	localparam int BYTE_W  = 8;
	localparam int ROW_W   = 7;
	localparam int COL_W   = 8;
	localparam int POINT_W = 21;

	localparam logic [POINT_W-1:0] LINE_FEED  = POINT_W'(10);
	localparam logic [COL_W-1:0]   COLS_RESET = COL_W'(122);

	// lead byte prefixes, compared against the top bits of the byte
	localparam logic [2:0] LEAD2_PFX = 3'h6;
	localparam logic [3:0] LEAD3_PFX = 4'hE;
	localparam logic [4:0] LEAD4_PFX = 5'h1E;

	typedef logic [1:0] pending_t;

endpackage
`default_nettype wire

@@ src/ucw_if.sv @@
`default_nettype none
interface ucw_byte_if;
	import ucw_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] stream_byte;
	modport source (output valid, output stream_byte, input ready);
	modport sink   (input valid, input stream_byte, output ready);
endinterface

interface ucw_cell_if;
	import ucw_pkg::*;
	logic               valid;
	logic               ready;
	logic [ROW_W-1:0]   cell_row;
	logic [COL_W-1:0]   cell_column;
	logic [POINT_W-1:0] code_point;
	modport source (output valid, output cell_row, output cell_column, output code_point,
		input ready);
	modport sink   (input valid, input cell_row, input cell_column, input code_point,
		output ready);
endinterface

interface ucw_cfg_if;
	import ucw_pkg::*;
	logic             valid;
	logic             ready;
	logic [COL_W-1:0] columns_in_use;
	modport source (output valid, output columns_in_use, input ready);
	modport sink   (input valid, input columns_in_use, output ready);
endinterface
`default_nettype wire

@@ src/utf8_char_cell_writer.sv @@
// UTF-8 byte stream to text cell write commands.
// stream (sink): one raw byte per word. Bytes are decoded into code points of
//   1 to 4 bytes; bytes after a lead byte are used as continuations as-is.
//   Invalid lead bytes are dropped.
// cmd (source): one write word per finished code point other than line feed,
//   carrying the cursor row, column and code point. A line feed only moves the
//   cursor to column 0 of the next row; the row sticks at MAX_LINES-1.
// cfg (sink): columns_in_use, always ready. 0 acts as 1, above MAX_COLUMNS acts
//   as MAX_COLUMNS. Write only while the block is idle.
// Output: the write word is registered and appears in the cycle after the byte that finishes it.
// Throughput: one byte per cycle. The decode and cursor update sit between the
//   accept edge and the cmd output register; the output register holds one
//   word, so a byte is taken whenever that register is empty or being drained.
// Stall: while cmd.ready is low with a word held, stream.ready is low and no
//   byte is taken; the held word stays stable.
// Reset (arst_n low): cursor at row 0 column 0, no sequence open, output empty,
//   columns_in_use back to 122.
`default_nettype none
module utf8_char_cell_writer #(
	parameter int MAX_COLUMNS = 192,
	parameter int MAX_LINES   = 108
) (
	input  logic     clk,
	input  logic     arst_n,
	ucw_byte_if.sink stream,
	ucw_cell_if.source cmd,
	ucw_cfg_if.sink  cfg
);
	import ucw_pkg::*;

	localparam logic [COL_W:0]   MaxCols = (COL_W+1)'(MAX_COLUMNS);
	localparam logic [ROW_W-1:0] LastRow = ROW_W'(MAX_LINES - 1);

	// decoder and cursor state
	logic [COL_W-1:0]   cols_q;
	pending_t           pend_q;
	logic [POINT_W-1:0] part_q;
	logic [COL_W-1:0]   col_q;
	logic [ROW_W-1:0]   row_q;

	// output register
	logic               out_v_q;
	logic [ROW_W-1:0]   out_row_q;
	logic [COL_W-1:0]   out_col_q;
	logic [POINT_W-1:0] out_pt_q;

	logic               accept;
	logic               finish;
	logic               emit;
	logic [POINT_W-1:0] fin_pt;
	pending_t           pend_d;
	logic [POINT_W-1:0] part_d;
	logic [COL_W:0]     eff_cols;
	logic [COL_W:0]     col_inc;
	logic [ROW_W-1:0]   row_inc;
	logic [COL_W-1:0]   col_d;
	logic [ROW_W-1:0]   row_d;
	logic [BYTE_W-1:0]  b;

	assign b          = stream.stream_byte;
	assign stream.ready = !out_v_q || cmd.ready;
	assign accept     = stream.valid && stream.ready;
	assign cfg.ready  = 1'b1;

	// effective column count
	always_comb begin
		if (cols_q == '0) begin
			eff_cols = (COL_W+1)'(1);
		end else if ({1'b0, cols_q} > MaxCols) begin
			eff_cols = MaxCols;
		end else begin
			eff_cols = {1'b0, cols_q};
		end
	end

	// byte decode
	always_comb begin
		finish = 1'b0;
		fin_pt = part_q;
		pend_d = pend_q;
		part_d = part_q;
		if (pend_q != '0) begin
			// continuation: top bits not checked
			part_d = {part_q[POINT_W-7:0], b[5:0]};
			pend_d = pend_q - pending_t'(1);
			fin_pt = part_d;
			finish = (pend_q == pending_t'(1));
		end else if (!b[7]) begin
			fin_pt = POINT_W'(b);
			finish = 1'b1;
		end else if (b[7:5] == LEAD2_PFX) begin
			part_d = POINT_W'(b[4:0]);
			pend_d = pending_t'(1);
		end else if (b[7:4] == LEAD3_PFX) begin
			part_d = POINT_W'(b[3:0]);
			pend_d = pending_t'(2);
		end else if (b[7:3] == LEAD4_PFX) begin
			part_d = POINT_W'(b[2:0]);
			pend_d = pending_t'(3);
		end
		// anything else is a bad lead byte: dropped, state kept
	end

	// cursor advance
	always_comb begin
		col_inc = {1'b0, col_q} + (COL_W+1)'(1);
		row_inc = (row_q == LastRow) ? LastRow : row_q + ROW_W'(1);
		emit    = finish && (fin_pt != LINE_FEED);
		col_d   = col_q;
		row_d   = row_q;
		if (finish) begin
			if (fin_pt == LINE_FEED || col_inc >= eff_cols) begin
				col_d = '0;
				row_d = row_inc;
			end else begin
				col_d = col_inc[COL_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q  <= COLS_RESET;
			pend_q  <= '0;
			part_q  <= '0;
			col_q   <= '0;
			row_q   <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				cols_q <= cfg.columns_in_use;
			end
			if (accept) begin
				pend_q  <= pend_d;
				part_q  <= part_d;
				col_q   <= col_d;
				row_q   <= row_d;
				out_v_q <= emit;
			end else if (cmd.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (accept && emit) begin
			out_row_q <= row_q;
			out_col_q <= col_q;
			out_pt_q  <= fin_pt;
		end
	end

	assign cmd.valid       = out_v_q;
	assign cmd.cell_row    = out_row_q;
	assign cmd.cell_column = out_col_q;
	assign cmd.code_point  = out_pt_q;

endmodule
`default_nettype wire

@@ src/ucw_checker.sv @@
`default_nettype none
module ucw_checker #(
	parameter int MAX_COLUMNS = 192,
	parameter int MAX_LINES   = 108
) (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [6:0]  cell_row,
	input wire logic [7:0]  cell_column,
	input wire logic [20:0] code_point
);

	// held word stays
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("cell word dropped while stalled");

	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(cell_row) && $stable(cell_column)
			&& $stable(code_point))
		else $error("cell word changed while stalled");

	// no byte taken while a word is held back
	a_no_take: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("byte taken during output stall");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (int'(cell_column) < MAX_COLUMNS) && (int'(cell_row) < MAX_LINES))
		else $error("cell outside screen");

	// line feed never written to a cell
	a_no_lf: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> code_point != 21'd10)
		else $error("line feed written as cell");

endmodule

bind utf8_char_cell_writer ucw_checker #(
	.MAX_COLUMNS(MAX_COLUMNS),
	.MAX_LINES  (MAX_LINES)
) u_ucw_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (stream.valid),
	.in_ready   (stream.ready),
	.out_valid  (cmd.valid),
	.out_ready  (cmd.ready),
	.cell_row   (cmd.cell_row),
	.cell_column(cmd.cell_column),
	.code_point (cmd.code_point)
);
`default_nettype wire
